// ===== src/tws_pkg.sv =====
// ---------------------------------------------------------------------------
// tws_pkg
// Shared types and constants for the two-wire sensor measurement master:
// phase encoding, opcodes, sequencer state and per-tick result record.
// ---------------------------------------------------------------------------
package tws_pkg;

  // Default parameter values
  localparam int RESET_PULSES_DEF = 9;
  localparam int WAIT_BITS_DEF    = 20;

  localparam int TIMEOUT_W = 20;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd5000;

  // Sensor command bytes
  localparam logic [7:0] CMD_TEMPERATURE = 8'h03;
  localparam logic [7:0] CMD_HUMIDITY    = 8'h05;

  // Reset sequence marker held in byte_index
  localparam logic [1:0] IDX_CONN_RESET = 2'd3;

  typedef enum logic [1:0] {
    OP_TICK        = 2'd0,
    OP_CONN_RESET  = 2'd1,
    OP_HUMIDITY    = 2'd2,
    OP_TEMPERATURE = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_RST_HI  = 5'd1,
    PH_RST_LO  = 5'd2,
    PH_ST_A    = 5'd3,
    PH_ST_B    = 5'd4,
    PH_ST_C    = 5'd5,
    PH_ST_D    = 5'd6,
    PH_ST_E    = 5'd7,
    PH_ST_F    = 5'd8,
    PH_WB_SET  = 5'd9,
    PH_WB_HI   = 5'd10,
    PH_WB_LO   = 5'd11,
    PH_WB_REL  = 5'd12,
    PH_WB_ACK  = 5'd13,
    PH_WAIT    = 5'd14,
    PH_RB_HI   = 5'd15,
    PH_RB_LO   = 5'd16,
    PH_RA_SET  = 5'd17,
    PH_RA_HI   = 5'd18,
    PH_RA_LO   = 5'd19,
    PH_FINISH  = 5'd20
  } phase_t;

  // Sequencer state (wait counter is kept apart, its width is a parameter)
  typedef struct packed {
    phase_t      phase;
    logic [3:0]  bit_count;
    logic [1:0]  hold_count;
    logic [7:0]  shift_byte;
    logic [1:0]  byte_index;
    logic [15:0] value_word;
    logic [7:0]  check_word;
    logic [1:0]  error_cnt;
    logic        measure_kind;
  } seq_state_t;

  // One result record per tick
  typedef struct packed {
    logic        sck;
    logic        data_out;
    logic        data_is_input;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  error_count;
    logic [15:0] reading;
    logic [7:0]  check_byte;
  } result_t;

endpackage

// ===== src/two_wire_sensor_measure_master_core.sv =====
// ---------------------------------------------------------------------------
// two_wire_sensor_measure_master_core
// Pin-level master for a two-wire humidity/temperature sensor, one tick
// of the pin waveform per transfer.
// ---------------------------------------------------------------------------
// Each input transfer is one 1 us tick: an opcode (tick only, connection
// reset, measure humidity, measure temperature) and the sampled DATA level.
// Each tick returns exactly one result transfer with the SCK and DATA pin
// levels to drive during that tick, busy/done flags and, on the done tick,
// the error count, the 16-bit reading and the unverified checksum byte.
// Commands are only taken while idle; the command tick is the first tick of
// the sequence. Ticks are processed one per clock while in_ready is high: the
// sequencer state is updated on the clock edge that takes the tick, and its
// result lands in a two-entry output buffer (result register plus skid), so
// in_ready drops only when two results are waiting downstream. The timeout
// register (cfg_data, reset 5000) is written through its own valid/ready
// channel, which is always ready, and should only be written while no
// sequence is running.
// ---------------------------------------------------------------------------
module two_wire_sensor_measure_master_core #(
  parameter int RESET_PULSES = tws_pkg::RESET_PULSES_DEF,  // 9..15 SCK pulses
  parameter int WAIT_BITS    = tws_pkg::WAIT_BITS_DEF      // wait counter width
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tws_pkg::TIMEOUT_W-1:0] cfg_data,
  // tick input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    opcode,
  input  logic                          data_in,
  // per-tick result
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          sck,
  output logic                          data_out,
  output logic                          data_is_input,
  output logic                          busy_res,
  output logic                          done_res,
  output logic [1:0]                    error_count,
  output logic [15:0]                   reading,
  output logic [7:0]                    check_byte
);

  // timeout register
  logic [tws_pkg::TIMEOUT_W-1:0] timeout_ticks;

  // sequencer state
  tws_pkg::seq_state_t  state;
  tws_pkg::seq_state_t  state_next;
  logic [WAIT_BITS-1:0] wait_count;
  logic [WAIT_BITS-1:0] wait_count_next;

  tws_pkg::result_t step_res;
  tws_pkg::result_t out_res;
  logic             in_xfer;

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= tws_pkg::TIMEOUT_RESET;
    end else if (cfg_valid) begin
      timeout_ticks <= cfg_data;
    end
  end

  // state advances once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= '0;
      wait_count <= '0;
    end else if (in_xfer) begin
      state      <= state_next;
      wait_count <= wait_count_next;
    end
  end

  tws_step #(
    .RESET_PULSES (RESET_PULSES),
    .WAIT_BITS    (WAIT_BITS)
  ) u_step (
    .state           (state),
    .wait_count      (wait_count),
    .opcode          (opcode),
    .data_in         (data_in),
    .timeout_ticks   (timeout_ticks),
    .state_next      (state_next),
    .wait_count_next (wait_count_next),
    .result          (step_res)
  );

  // result register + skid entry
  tws_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (step_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign sck           = out_res.sck;
  assign data_out      = out_res.data_out;
  assign data_is_input = out_res.data_is_input;
  assign busy_res      = out_res.busy_res;
  assign done_res      = out_res.done_res;
  assign error_count   = out_res.error_count;
  assign reading       = out_res.reading;
  assign check_byte    = out_res.check_byte;

endmodule

// ===== src/tws_step.sv =====
// ---------------------------------------------------------------------------
// tws_step
// Next-state and pin/status logic for one tick of the sensor sequencer.
// ---------------------------------------------------------------------------
module tws_step #(
  parameter int RESET_PULSES = tws_pkg::RESET_PULSES_DEF,
  parameter int WAIT_BITS    = tws_pkg::WAIT_BITS_DEF
) (
  input  tws_pkg::seq_state_t           state,
  input  logic [WAIT_BITS-1:0]          wait_count,
  input  logic [1:0]                    opcode,
  input  logic                          data_in,
  input  logic [tws_pkg::TIMEOUT_W-1:0] timeout_ticks,
  output tws_pkg::seq_state_t           state_next,
  output logic [WAIT_BITS-1:0]          wait_count_next,
  output tws_pkg::result_t              result
);

  // compare width wide enough for both the wait count + 1 and the timeout
  localparam int CW = (WAIT_BITS + 1 > tws_pkg::TIMEOUT_W + 1) ?
                      WAIT_BITS + 1 : tws_pkg::TIMEOUT_W + 1;

  logic [CW-1:0] wait_inc;
  logic [CW-1:0] wait_lim;
  logic [CW-1:0] limit_eff;

  assign wait_inc  = CW'(wait_count) + CW'(1);
  assign wait_lim  = {{(CW-WAIT_BITS){1'b0}}, {WAIT_BITS{1'b1}}};
  assign limit_eff = (timeout_ticks == '0) ? CW'(1) : CW'(timeout_ticks);

  always_comb begin
    tws_pkg::seq_state_t s;
    logic [WAIT_BITS-1:0] w;
    logic [4:0]           bc_inc;
    logic [2:0]           hc_inc;
    logic                 b;
    logic                 ack_lvl;
    logic                 sck;
    logic                 dout;
    logic                 rel;
    logic                 busy;
    logic                 done;

    s       = state;
    w       = wait_count;
    sck     = 1'b0;
    dout    = 1'b1;
    rel     = 1'b1;
    busy    = 1'b1;
    done    = 1'b0;

    // command accepted only while idle; that tick is the first of the sequence
    if (state.phase == tws_pkg::PH_IDLE && opcode != tws_pkg::OP_TICK) begin
      s.bit_count  = '0;
      s.hold_count = '0;
      w            = '0;
      s.value_word = '0;
      s.check_word = '0;
      s.error_cnt  = '0;
      if (opcode == tws_pkg::OP_CONN_RESET) begin
        s.byte_index = tws_pkg::IDX_CONN_RESET;
        s.phase      = tws_pkg::PH_RST_HI;
      end else begin
        s.byte_index   = '0;
        s.measure_kind = (opcode == tws_pkg::OP_TEMPERATURE);
        s.shift_byte   = (opcode == tws_pkg::OP_TEMPERATURE) ?
                         tws_pkg::CMD_TEMPERATURE : tws_pkg::CMD_HUMIDITY;
        s.phase        = tws_pkg::PH_ST_A;
      end
    end

    bc_inc  = {1'b0, s.bit_count} + 5'd1;
    hc_inc  = {1'b0, s.hold_count} + 3'd1;
    b       = s.shift_byte[7];
    ack_lvl = (s.byte_index >= 2'd2);

    case (s.phase)
      tws_pkg::PH_RST_HI: begin
        sck = 1'b1; dout = 1'b1; rel = 1'b0; s.phase = tws_pkg::PH_RST_LO;
      end
      tws_pkg::PH_RST_LO: begin
        sck = 1'b0; dout = 1'b1; rel = 1'b0;
        if (bc_inc >= 5'(RESET_PULSES)) begin
          s.bit_count = '0;
          s.phase     = tws_pkg::PH_ST_A;
        end else begin
          s.bit_count = bc_inc[3:0];
          s.phase     = tws_pkg::PH_RST_HI;
        end
      end
      tws_pkg::PH_ST_A: begin
        sck = 1'b0; dout = 1'b1; rel = 1'b0; s.phase = tws_pkg::PH_ST_B;
      end
      tws_pkg::PH_ST_B: begin
        sck = 1'b1; dout = 1'b1; rel = 1'b0; s.phase = tws_pkg::PH_ST_C;
      end
      tws_pkg::PH_ST_C: begin
        sck = 1'b1; dout = 1'b0; rel = 1'b0;
        s.hold_count = '0;
        s.phase      = tws_pkg::PH_ST_D;
      end
      tws_pkg::PH_ST_D: begin
        sck = 1'b0; dout = 1'b0; rel = 1'b0;
        if (hc_inc >= 3'd3) begin
          s.hold_count = '0;
          s.phase      = tws_pkg::PH_ST_E;
        end else begin
          s.hold_count = hc_inc[1:0];
        end
      end
      tws_pkg::PH_ST_E: begin
        sck = 1'b1; dout = 1'b0; rel = 1'b0; s.phase = tws_pkg::PH_ST_F;
      end
      tws_pkg::PH_ST_F: begin
        sck = 1'b1; dout = 1'b1; rel = 1'b0;
        s.bit_count = '0;
        s.phase     = (s.byte_index == tws_pkg::IDX_CONN_RESET) ?
                      tws_pkg::PH_FINISH : tws_pkg::PH_WB_SET;
      end
      tws_pkg::PH_WB_SET: begin
        sck = 1'b0; dout = b; rel = 1'b0;
        s.hold_count = '0;
        s.phase      = tws_pkg::PH_WB_HI;
      end
      tws_pkg::PH_WB_HI: begin
        sck = 1'b1; dout = b; rel = 1'b0;
        if (hc_inc >= 3'd3) begin
          s.hold_count = '0;
          s.phase      = tws_pkg::PH_WB_LO;
        end else begin
          s.hold_count = hc_inc[1:0];
        end
      end
      tws_pkg::PH_WB_LO: begin
        sck = 1'b0; dout = b; rel = 1'b0;
        s.shift_byte = {s.shift_byte[6:0], 1'b0};
        if (bc_inc >= 5'd8) begin
          s.bit_count = '0;
          s.phase     = tws_pkg::PH_WB_REL;
        end else begin
          s.bit_count = bc_inc[3:0];
          s.phase     = tws_pkg::PH_WB_SET;
        end
      end
      tws_pkg::PH_WB_REL: begin
        sck = 1'b0; dout = 1'b1; rel = 1'b0; s.phase = tws_pkg::PH_WB_ACK;
      end
      tws_pkg::PH_WB_ACK: begin
        // sensor ack: a high level here is a missing acknowledge
        sck = 1'b1; dout = 1'b1; rel = 1'b1;
        s.error_cnt = s.error_cnt + {1'b0, data_in};
        w           = '0;
        s.phase     = tws_pkg::PH_WAIT;
      end
      tws_pkg::PH_WAIT: begin
        sck = 1'b0; dout = 1'b1; rel = 1'b1;
        if (!data_in) begin
          s.bit_count  = '0;
          s.shift_byte = '0;
          s.phase      = tws_pkg::PH_RB_HI;
        end else begin
          if (wait_inc >= limit_eff || wait_inc >= wait_lim) begin
            s.error_cnt  = s.error_cnt + 2'd1;
            s.value_word = '0;
            s.check_word = '0;
            done         = 1'b1;
            s.phase      = tws_pkg::PH_IDLE;
          end
          w = wait_inc[WAIT_BITS-1:0];
        end
      end
      tws_pkg::PH_RB_HI: begin
        sck = 1'b1; dout = 1'b1; rel = 1'b1;
        s.shift_byte = {s.shift_byte[6:0], data_in};
        s.phase      = tws_pkg::PH_RB_LO;
      end
      tws_pkg::PH_RB_LO: begin
        sck = 1'b0; dout = 1'b1; rel = 1'b1;
        if (bc_inc >= 5'd8) begin
          s.bit_count = '0;
          case (s.byte_index)
            2'd0:    s.value_word[15:8] = s.shift_byte;
            2'd1:    s.value_word[7:0]  = s.shift_byte;
            default: s.check_word       = s.shift_byte;
          endcase
          s.phase = tws_pkg::PH_RA_SET;
        end else begin
          s.bit_count = bc_inc[3:0];
          s.phase     = tws_pkg::PH_RB_HI;
        end
      end
      tws_pkg::PH_RA_SET: begin
        sck = 1'b0; dout = ack_lvl; rel = 1'b0;
        s.hold_count = '0;
        s.phase      = tws_pkg::PH_RA_HI;
      end
      tws_pkg::PH_RA_HI: begin
        sck = 1'b1; dout = ack_lvl; rel = 1'b0;
        if (hc_inc >= 3'd3) begin
          s.hold_count = '0;
          s.phase      = tws_pkg::PH_RA_LO;
        end else begin
          s.hold_count = hc_inc[1:0];
        end
      end
      tws_pkg::PH_RA_LO: begin
        sck = 1'b0; dout = ack_lvl; rel = 1'b0;
        s.byte_index = s.byte_index + 2'd1;
        if (s.byte_index == tws_pkg::IDX_CONN_RESET) begin
          s.phase = tws_pkg::PH_FINISH;
        end else begin
          s.bit_count  = '0;
          s.shift_byte = '0;
          s.phase      = tws_pkg::PH_RB_HI;
        end
      end
      tws_pkg::PH_FINISH: begin
        sck = 1'b0; dout = 1'b1; rel = 1'b0; done = 1'b1;
        s.phase = tws_pkg::PH_IDLE;
      end
      default: begin
        // idle, or an unused phase code
        s.phase = tws_pkg::PH_IDLE;
        busy    = 1'b0;
      end
    endcase

    state_next      = s;
    wait_count_next = w;

    result.sck           = sck;
    result.data_out      = dout;
    result.data_is_input = rel;
    result.busy_res      = busy;
    result.done_res      = done;
    result.error_count   = done ? s.error_cnt  : 2'd0;
    result.reading       = done ? s.value_word : 16'd0;
    result.check_byte    = done ? s.check_word : 8'd0;
  end

endmodule

// ===== src/tws_skid.sv =====
// ---------------------------------------------------------------------------
// tws_skid
// Two-entry output buffer: result register plus skid register, so the
// input side keeps taking ticks while one result waits downstream.
// ---------------------------------------------------------------------------
module tws_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tws_pkg::result_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output tws_pkg::result_t out_data
);

  logic             main_valid;
  tws_pkg::result_t main_data;
  logic             skid_valid;
  tws_pkg::result_t skid_data;
  logic             push;
  logic             pop;

  assign in_ready  = !skid_valid;
  assign push      = in_valid && in_ready;
  assign pop       = main_valid && out_ready;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (!main_valid || pop) begin
      main_valid <= push;
      if (push) begin
        main_data <= in_data;
      end
    end else if (push) begin
      skid_data  <= in_data;
      skid_valid <= 1'b1;
    end
  end

endmodule

// ===== dv/tws_tick_scoreboard_pkg.sv =====
// ---------------------------------------------------------------------------
// tws_tick_scoreboard_pkg
// Per-tick pin waveform predictor and in-order result check for the
// two-wire sensor measurement master.
// ---------------------------------------------------------------------------
package tws_tick_scoreboard_pkg;
  import tws_pkg::*;

  localparam int WAIT_W = WAIT_BITS_DEF;
  localparam logic [WAIT_W:0] WAIT_LIM = {1'b0, {WAIT_W{1'b1}}};

  class pin_scoreboard;
    phase_t               ph;
    logic [3:0]           bit_cnt;
    logic [1:0]           hold_cnt;
    logic [WAIT_W-1:0]    wait_cnt;
    logic [7:0]           shreg;
    logic [1:0]           byte_idx;
    logic [15:0]          value;
    logic [7:0]           chk;
    logic [1:0]           errs;
    logic                 temp_kind;
    logic [TIMEOUT_W-1:0] tmo_ticks;
    result_t              pending_pins[$];
    int                   failures;

    function new();
      ph        = PH_IDLE;
      bit_cnt   = '0;
      hold_cnt  = '0;
      wait_cnt  = '0;
      shreg     = '0;
      byte_idx  = '0;
      value     = '0;
      chk       = '0;
      errs      = '0;
      temp_kind = 1'b0;
      tmo_ticks = TIMEOUT_RESET;
      failures  = 0;
    endfunction

    // Advance the sequencer by one accepted tick and queue the pin levels.
    function void note_tick(op_t op, logic din);
      result_t         r;
      logic            ack_lvl;
      logic [WAIT_W:0] n;
      logic [WAIT_W:0] t;
      r = '0;
      {r.sck, r.data_out, r.data_is_input} = 3'b011;
      r.busy_res = 1'b1;
      ack_lvl = (byte_idx >= 2'd2);

      if (ph == PH_IDLE && op != OP_TICK) begin
        bit_cnt  = '0;
        hold_cnt = '0;
        wait_cnt = '0;
        value    = '0;
        chk      = '0;
        errs     = '0;
        if (op == OP_CONN_RESET) begin
          byte_idx = IDX_CONN_RESET;
          ph       = PH_RST_HI;
        end else begin
          byte_idx  = '0;
          temp_kind = (op == OP_TEMPERATURE);
          shreg     = temp_kind ? CMD_TEMPERATURE : CMD_HUMIDITY;
          ph        = PH_ST_A;
        end
      end

      case (ph)
        PH_RST_HI: begin
          {r.sck, r.data_out, r.data_is_input} = 3'b110;
          ph = PH_RST_LO;
        end
        PH_RST_LO: begin
          {r.sck, r.data_out, r.data_is_input} = 3'b010;
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt >= RESET_PULSES_DEF) begin
            bit_cnt = '0;
            ph      = PH_ST_A;
          end else begin
            ph = PH_RST_HI;
          end
        end
        PH_ST_A: begin
          {r.sck, r.data_out, r.data_is_input} = 3'b010;
          ph = PH_ST_B;
        end
        PH_ST_B: begin
          {r.sck, r.data_out, r.data_is_input} = 3'b110;
          ph = PH_ST_C;
        end
        PH_ST_C: begin
          {r.sck, r.data_out, r.data_is_input} = 3'b100;
          hold_cnt = '0;
          ph       = PH_ST_D;
        end
        PH_ST_D: begin
          {r.sck, r.data_out, r.data_is_input} = 3'b000;
          hold_cnt = hold_cnt + 2'd1;
          if (hold_cnt >= 2'd3) begin
            hold_cnt = '0;
            ph       = PH_ST_E;
          end
        end
        PH_ST_E: begin
          {r.sck, r.data_out, r.data_is_input} = 3'b100;
          ph = PH_ST_F;
        end
        PH_ST_F: begin
          {r.sck, r.data_out, r.data_is_input} = 3'b110;
          bit_cnt = '0;
          ph = (byte_idx == IDX_CONN_RESET) ? PH_FINISH : PH_WB_SET;
        end
        PH_WB_SET: begin
          {r.sck, r.data_out, r.data_is_input} = {1'b0, shreg[7], 1'b0};
          hold_cnt = '0;
          ph       = PH_WB_HI;
        end
        PH_WB_HI: begin
          {r.sck, r.data_out, r.data_is_input} = {1'b1, shreg[7], 1'b0};
          hold_cnt = hold_cnt + 2'd1;
          if (hold_cnt >= 2'd3) begin
            hold_cnt = '0;
            ph       = PH_WB_LO;
          end
        end
        PH_WB_LO: begin
          {r.sck, r.data_out, r.data_is_input} = {1'b0, shreg[7], 1'b0};
          shreg   = {shreg[6:0], 1'b0};
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt >= 4'd8) begin
            bit_cnt = '0;
            ph      = PH_WB_REL;
          end else begin
            ph = PH_WB_SET;
          end
        end
        PH_WB_REL: begin
          {r.sck, r.data_out, r.data_is_input} = 3'b010;
          ph = PH_WB_ACK;
        end
        PH_WB_ACK: begin
          {r.sck, r.data_out, r.data_is_input} = 3'b111;
          errs     = errs + 2'(din);
          wait_cnt = '0;
          ph       = PH_WAIT;
        end
        PH_WAIT: begin
          {r.sck, r.data_out, r.data_is_input} = 3'b011;
          if (!din) begin
            bit_cnt = '0;
            shreg   = '0;
            ph      = PH_RB_HI;
          end else begin
            n = {1'b0, wait_cnt} + 1'b1;
            t = (tmo_ticks == '0) ? (WAIT_W+1)'(1) : (WAIT_W+1)'(tmo_ticks);
            if (n >= t || n >= WAIT_LIM) begin
              errs       = errs + 2'd1;
              value      = '0;
              chk        = '0;
              r.done_res = 1'b1;
              ph         = PH_IDLE;
            end
            wait_cnt = n[WAIT_W-1:0];
          end
        end
        PH_RB_HI: begin
          {r.sck, r.data_out, r.data_is_input} = 3'b111;
          shreg = {shreg[6:0], din};
          ph    = PH_RB_LO;
        end
        PH_RB_LO: begin
          {r.sck, r.data_out, r.data_is_input} = 3'b011;
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt >= 4'd8) begin
            bit_cnt = '0;
            if (byte_idx == 2'd0) value[15:8] = shreg;
            else if (byte_idx == 2'd1) value[7:0] = shreg;
            else chk = shreg;
            ph = PH_RA_SET;
          end else begin
            ph = PH_RB_HI;
          end
        end
        PH_RA_SET: begin
          {r.sck, r.data_out, r.data_is_input} = {1'b0, ack_lvl, 1'b0};
          hold_cnt = '0;
          ph       = PH_RA_HI;
        end
        PH_RA_HI: begin
          {r.sck, r.data_out, r.data_is_input} = {1'b1, ack_lvl, 1'b0};
          hold_cnt = hold_cnt + 2'd1;
          if (hold_cnt >= 2'd3) begin
            hold_cnt = '0;
            ph       = PH_RA_LO;
          end
        end
        PH_RA_LO: begin
          {r.sck, r.data_out, r.data_is_input} = {1'b0, ack_lvl, 1'b0};
          byte_idx = byte_idx + 2'd1;
          if (byte_idx == 2'd3) begin
            ph = PH_FINISH;
          end else begin
            bit_cnt = '0;
            shreg   = '0;
            ph      = PH_RB_HI;
          end
        end
        PH_FINISH: begin
          {r.sck, r.data_out, r.data_is_input} = 3'b010;
          r.done_res = 1'b1;
          ph         = PH_IDLE;
        end
        default: begin
          ph         = PH_IDLE;
          r.busy_res = 1'b0;
        end
      endcase

      if (r.done_res) begin
        r.error_count = errs;
        r.reading     = value;
        r.check_byte  = chk;
      end
      pending_pins.push_back(r);
    endfunction

    function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_pins.size() == 0) begin
        $error("result transfer with no tick outstanding");
        failures++;
        return;
      end
      want = pending_pins.pop_front();
      cmp_field("sck", want.sck, got.sck);
      cmp_field("data_out", want.data_out, got.data_out);
      cmp_field("data_is_input", want.data_is_input, got.data_is_input);
      cmp_field("busy_res", want.busy_res, got.busy_res);
      cmp_field("done_res", want.done_res, got.done_res);
      cmp_field("error_count", want.error_count, got.error_count);
      cmp_field("reading", want.reading, got.reading);
      cmp_field("check_byte", want.check_byte, got.check_byte);
    endfunction
  endclass

endpackage

// ===== dv/tb_two_wire_sensor_measure_master_core.sv =====
// ---------------------------------------------------------------------------
// tb_two_wire_sensor_measure_master_core
// Self-checking bench for the two-wire sensor measurement master.
// ---------------------------------------------------------------------------
// Feeds 1 us ticks (opcode + sampled DATA) and checks every per-tick result
// against a per-tick predictor of the pin waveform. The DATA level fed
// back mimics a sensor: command acknowledge, a wait with DATA high, then
// three bytes MSB first. Missing acknowledges, timeouts and commands given
// while busy are mixed in. The run walks through several timeout settings
// and backpressure modes on both handshakes.
// ---------------------------------------------------------------------------
module tb_two_wire_sensor_measure_master_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tws_pkg::*;
  import tws_tick_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_TICKS = 75;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [TIMEOUT_W-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           opcode = OP_TICK;
  logic                 data_in = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 sck;
  logic                 data_out;
  logic                 data_is_input;
  logic                 busy_res;
  logic                 done_res;
  logic [1:0]           error_count;
  logic [15:0]          reading;
  logic [7:0]           check_byte;

  pin_scoreboard sb;
  int            gap_pct = 0;      // chance the sender idles before a tick
  int            stall_pct = 0;    // chance the receiver holds off a cycle
  int            ticks_sent = 0;
  int            cycle_count = 0;
  bit            pause_in_wait = 1'b0;

  two_wire_sensor_measure_master_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .data_in       (data_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sck           (sck),
    .data_out      (data_out),
    .data_is_input (data_is_input),
    .busy_res      (busy_res),
    .done_res      (done_res),
    .error_count   (error_count),
    .reading       (reading),
    .check_byte    (check_byte)
  );

  always #10 clk = ~clk;

  // Hard stop in case a handshake never completes.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver side: random hold-off, redrawn every cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Every result transfer is checked against the oldest predicted tick.
  always @(posedge clk) begin
    result_t got;
    if (!rst && out_valid && out_ready) begin
      got.sck           = sck;
      got.data_out      = data_out;
      got.data_is_input = data_is_input;
      got.busy_res      = busy_res;
      got.done_res      = done_res;
      got.error_count   = error_count;
      got.reading       = reading;
      got.check_byte    = check_byte;
      sb.check_result(got);
    end
  end

  // One tick transfer. Valid is only lowered during a sender gap or a drain, so
  // it is never dropped and raised in the same step.
  task automatic send_tick(input op_t op, input logic din);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    data_in  <= din;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(op, din);
    ticks_sent++;
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending_pins.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Timeout register write; only called with the sequencer idle.
  task automatic write_timeout(input logic [TIMEOUT_W-1:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    sb.tmo_ticks = v;
  endtask

  // Issue one command and play the sensor side until the sequence ends.
  // The DATA level fed back follows the predicted phase: acknowledge level,
  // wait_hi high samples before the sensor answers, then 24 payload bits.
  // noise_pct injects random opcodes while busy, which must be ignored.
  task automatic run_sequence(input op_t cmd, input logic ack_bad, input int wait_hi,
                              input logic [23:0] payload, input int noise_pct);
    int   waited;
    int   rd_bits;
    op_t  op;
    logic din;
    waited  = 0;
    rd_bits = 0;
    send_tick(cmd, 1'($urandom_range(0, 1)));
    while (sb.ph != PH_IDLE) begin
      // mid-sequence pause until the pipe is empty
      if (pause_in_wait && sb.ph == PH_WAIT) begin
        drain_results();
        pause_in_wait = 1'b0;
      end
      op = OP_TICK;
      if ($urandom_range(0, 99) < noise_pct) op = op_t'($urandom_range(0, 3));
      case (sb.ph)
        PH_WB_ACK: din = ack_bad;
        PH_WAIT: begin
          din = (waited < wait_hi);
          waited++;
        end
        PH_RB_HI: begin
          din = payload[23 - rd_bits];
          rd_bits++;
        end
        default: din = 1'($urandom_range(0, 1));
      endcase
      send_tick(op, din);
    end
  endtask

  // One random scenario: idle ticks, a connection reset, or a measurement
  // that may lose its acknowledge or time out.
  task automatic random_sequence();
    int          sel;
    int          eff;
    int          wait_hi;
    int          noise;
    logic [23:0] payload;
    sel   = $urandom_range(0, 99);
    noise = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
    if (sel < 8) begin
      repeat ($urandom_range(1, 4)) send_tick(OP_TICK, 1'($urandom_range(0, 1)));
    end else if (sel < 22) begin
      run_sequence(OP_CONN_RESET, 1'b0, 0, '0, noise);
    end else begin
      eff = (sb.tmo_ticks == '0) ? 1 : int'(sb.tmo_ticks);
      if (eff <= 64 && $urandom_range(0, 99) < 30)
        wait_hi = eff + $urandom_range(0, 3);           // runs into the timeout
      else
        wait_hi = $urandom_range(0, (eff - 1 < 25) ? eff - 1 : 25);
      case ($urandom_range(0, 9))
        0:       payload = '0;
        1:       payload = '1;
        default: payload = 24'($urandom);
      endcase
      run_sequence($urandom_range(0, 1) ? OP_TEMPERATURE : OP_HUMIDITY,
                   1'($urandom_range(0, 99) < 15), wait_hi, payload, noise);
    end
  endtask

  initial begin
    int          target;
    logic [19:0] tmo;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle ticks, connection reset with commands while busy,
    // both measurements with extreme readings, missing acknowledge,
    // timeout at a limit of one and at zero (treated as one).
    send_tick(OP_TICK, 1'b0);
    send_tick(OP_TICK, 1'b1);
    run_sequence(OP_CONN_RESET, 1'b0, 0, '0, 30);
    run_sequence(OP_HUMIDITY, 1'b0, 3, 24'hFFFFFF, 0);
    run_sequence(OP_TEMPERATURE, 1'b1, 0, 24'h000000, 50);
    run_sequence(OP_HUMIDITY, 1'b0, 0, 24'hA55A3C, 0);
    write_timeout(20'd1);
    run_sequence(OP_TEMPERATURE, 1'b1, 5, '0, 0);
    write_timeout(20'd0);
    run_sequence(OP_HUMIDITY, 1'b0, 1, '0, 0);
    send_tick(OP_TICK, 1'b1);

    // Random phases, each with its own timeout and backpressure mode.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       tmo = TIMEOUT_RESET;
        1:       tmo = 20'd1;
        2:       tmo = 20'hFFFFF;
        3:       tmo = 20'd0;
        4:       tmo = 20'd3;
        5:       tmo = 20'($urandom_range(2, 40));
        6:       tmo = 20'd12;
        default: tmo = 20'($urandom_range(1, 200));
      endcase
      write_timeout(tmo);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 60; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 60; end
        default: begin gap_pct = 38; stall_pct = 38; end
      endcase
      pause_in_wait = (p == 4);
      target = ticks_sent + PHASE_TICKS;
      while (ticks_sent < target) random_sequence();
    end

    drain_results();
    if (sb.failures == 0 && sb.pending_pins.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
